FILE: design/gbc_pkg.sv
// Shared types, constants and round functions for the GOST 28147-89 cipher core.
// No dependencies; every other file of the core imports this package.
`timescale 1ns / 1ps

package gbc_pkg;

  localparam int WordWidth    = 32;
  localparam int BlockWidth   = 2 * WordWidth;
  localparam int NumKeyWords  = 8;
  localparam int KeyIdxWidth  = $clog2(NumKeyWords);
  localparam int CfgIdxWidth  = KeyIdxWidth + 1;
  localparam int NumRounds    = 32;
  localparam int RoundWidth   = $clog2(NumRounds);
  localparam int NumNibbles   = WordWidth / 4;
  localparam int RotateAmount = 11;

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [NumKeyWords-1:0][WordWidth-1:0] key_bank_t;

  typedef enum logic {
    ModeEncrypt = 1'b0,
    ModeDecrypt = 1'b1
  } mode_e;

  // Data that travels from one round cell to the next.
  typedef struct packed {
    mode_e mode;
    word_t left;
    word_t right;
  } stage_t;

  localparam logic [3:0] Sbox [NumNibbles][16] = '{
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd9,  4'd8,  4'd14, 4'd5,  4'd12, 4'd0},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
  };

  // Encryption runs subkeys 0..7 three times, then 7..0; decryption runs
  // 0..7 once, then 7..0 three times. Counting down is the inverted low bits.
  function automatic logic [KeyIdxWidth-1:0] subkey_index(mode_e mode,
                                                          logic [RoundWidth-1:0] rnd);
    logic ascending;
    ascending = (mode == ModeEncrypt) ? !(rnd[RoundWidth-1] && rnd[RoundWidth-2])
                                      : (rnd[RoundWidth-1:RoundWidth-2] == 2'b00);
    return ascending ? rnd[KeyIdxWidth-1:0] : ~rnd[KeyIdxWidth-1:0];
  endfunction

  // Round function: modular add, nibble substitution, rotate left by 11.
  function automatic word_t mix_word(word_t half, word_t subkey);
    word_t sum;
    word_t subst;
    sum = half + subkey;
    for (int n = 0; n < NumNibbles; n++) begin
      subst[4*n +: 4] = Sbox[n][sum[4*n +: 4]];
    end
    return {subst[WordWidth-RotateAmount-1:0], subst[WordWidth-1:WordWidth-RotateAmount]};
  endfunction

endpackage

FILE: design/gbc_if.sv
// Handshake channels of the cipher core: block input, block output, key writes.
// Depends on gbc_pkg for the field widths.
`timescale 1ns / 1ps

interface gbc_in_if import gbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [BlockWidth-1:0] block_in;

  modport source (output valid, mode, block_in, input ready);
  modport sink (input valid, mode, block_in, output ready);
endinterface

interface gbc_out_if import gbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BlockWidth-1:0] block_out;

  modport source (output valid, block_out, input ready);
  modport sink (input valid, block_out, output ready);
endinterface

interface gbc_cfg_if import gbc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [WordWidth-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/gbc_key_regs.sv
// Eight 32-bit key registers written through the configuration channel.
// Depends on gbc_pkg and gbc_cfg_if.
`timescale 1ns / 1ps

module gbc_key_regs import gbc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  gbc_cfg_if.sink       cfg_i,
  output key_bank_t     keys_o
);

  key_bank_t keys_q;

  assign cfg_i.ready = 1'b1;

  // Writes to an index past the last key word are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else if (cfg_i.valid && (cfg_i.index < CfgIdxWidth'(NumKeyWords))) begin
      keys_q[cfg_i.index[KeyIdxWidth-1:0]] <= cfg_i.data;
    end
  end

  assign keys_o = keys_q;

endmodule

FILE: design/gbc_round_cell.sv
// One Feistel round of the cipher, registered, with its own valid bit.
// Depends on gbc_pkg; instantiated 32 times in a chain by the top level.
`timescale 1ns / 1ps

module gbc_round_cell import gbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [RoundWidth-1:0] round_i,
  input  key_bank_t             keys_i,
  input  logic                  valid_i,
  input  stage_t                data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output stage_t                data_o,
  input  logic                  ready_i
);

  logic   valid_q, valid_d;
  stage_t data_q, data_d;
  word_t  subkey;
  logic   load;

  assign subkey  = keys_i[subkey_index(data_i.mode, round_i)];
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    data_d.mode  = data_i.mode;
    data_d.left  = data_i.right;
    data_d.right = data_i.left ^ mix_word(data_i.right, subkey);
    valid_d      = load || (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset; it is qualified by the valid bit.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(data_q))
    else $error("round cell lost or changed a stalled block");

  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> valid_q)
    else $error("round cell dropped a block it took");

  a_drain_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ready_i && !valid_i |=> !valid_q)
    else $error("round cell repeated a block after its transfer");

endmodule

FILE: design/gost_block_cipher_core.sv
// Channel   Dir  Fields                      Transfer when
// cfg_i     in   index[3:0], data[31:0]      valid & ready (ready is always high)
// in_i      in   mode, block_in[63:0]        valid & ready
// out_o     out  block_out[63:0]             valid & ready
//
// One block enters per cycle while in_i.ready is high; each block passes
// through the chain of 32 registered round cells, one register per round.
// Reset clears all valid bits and sets the eight key words to zero.
// A stalled output holds the last cell; earlier cells keep moving until the
// gaps ahead of them are filled, and only then is in_i.ready dropped.
// Depends on gbc_pkg, gbc_if, gbc_key_regs and gbc_round_cell.
`timescale 1ns / 1ps

module gost_block_cipher_core import gbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  gbc_cfg_if.sink  cfg_i,
  gbc_in_if.sink   in_i,
  gbc_out_if.source out_o
);

  key_bank_t keys;
  logic      node_valid [NumRounds+1];
  logic      node_ready [NumRounds+1];
  stage_t    node_data  [NumRounds+1];

  gbc_key_regs u_key_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .keys_o (keys)
  );

  assign node_valid[0]     = in_i.valid;
  assign node_data[0].mode = mode_e'(in_i.mode);
  assign node_data[0].left = in_i.block_in[BlockWidth-1:WordWidth];
  assign node_data[0].right = in_i.block_in[WordWidth-1:0];
  assign in_i.ready        = node_ready[0];

  for (genvar i = 0; i < NumRounds; i++) begin : g_round
    gbc_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (RoundWidth'(i)),
      .keys_i  (keys),
      .valid_i (node_valid[i]),
      .data_i  (node_data[i]),
      .ready_o (node_ready[i]),
      .valid_o (node_valid[i+1]),
      .data_o  (node_data[i+1]),
      .ready_i (node_ready[i+1])
    );
  end

  // Every cell swaps the halves, the last one too, so the output takes them crossed to undo it.
  assign out_o.valid              = node_valid[NumRounds];
  assign out_o.block_out          = {node_data[NumRounds].right, node_data[NumRounds].left};
  assign node_ready[NumRounds]    = out_o.ready;

endmodule

FILE: tb/gost_block_cipher_core_tb.sv
// Self-checking testbench for the GOST 28147-89 ECB cipher core.
// Depends on gbc_pkg, the gbc_if channel interfaces and gost_block_cipher_core.
`timescale 1ns / 1ps

module gost_block_cipher_core_tb import gbc_pkg::*; ();

  localparam int IdlePercent  = 10;
  localparam int MaxGap       = 1;
  localparam int LongStall    = 200;
  localparam int RandomItems  = 1150;
  localparam int RandomPhases = 5;
  localparam int DrainCycles  = NumRounds + 8;
  localparam int TimeoutNs    = 2_000_000;

  localparam logic [CfgIdxWidth-1:0] FirstUnusedIndex = CfgIdxWidth'(NumKeyWords);
  localparam logic [CfgIdxWidth-1:0] LastCfgIndex     = '1;

  typedef logic [BlockWidth-1:0] block_t;

  typedef struct packed {
    logic [CfgIdxWidth-1:0] index;
    word_t                  data;
  } reg_write_t;

  // Tracks the key bank, computes the cipher of every accepted block and
  // checks the results in arrival order.
  class cipher_scoreboard;
    logic [NumNibbles-1:0][63:0] sbox_rows;
    word_t                       key_bank [NumKeyWords];
    block_t                      expected_blocks [$];
    int unsigned                 errors;
    int unsigned                 checked;
    int unsigned                 accepted;
    int unsigned                 decrypts;

    function new();
      // Entry i of each box sits in nibble i, counted from the low end.
      sbox_rows[0] = 64'h35F7C1B6E08D29A4;
      sbox_rows[1] = 64'h95701832AFD6C4BE;
      sbox_rows[2] = 64'hB9067CFE243AD185;
      sbox_rows[3] = 64'h0C5E896B24F31AD7;
      sbox_rows[4] = 64'h2B30E9A48DF517C6;
      sbox_rows[5] = 64'hEFC95863D1270AB4;
      sbox_rows[6] = 64'hC2867EA095F314BD;
      sbox_rows[7] = 64'hC8B6E3294A750DF1;
      foreach (key_bank[k]) key_bank[k] = '0;
      errors   = 0;
      checked  = 0;
      accepted = 0;
      decrypts = 0;
    endfunction

    function void write_key(logic [CfgIdxWidth-1:0] index, word_t data);
      if (index < NumKeyWords) key_bank[index[KeyIdxWidth-1:0]] = data;
    endfunction

    function word_t round_mix(word_t half, word_t subkey);
      word_t sum;
      word_t subst;
      int    n;
      sum = half + subkey;
      for (n = 0; n < NumNibbles; n++) begin
        subst[4*n +: 4] = sbox_rows[n][4*sum[4*n +: 4] +: 4];
      end
      return (subst << RotateAmount) | (subst >> (WordWidth - RotateAmount));
    endfunction

    function int round_key(mode_e mode, int rnd);
      if (mode == ModeEncrypt) return (rnd < 24) ? rnd % 8 : 7 - rnd % 8;
      return (rnd < 8) ? rnd : 7 - rnd % 8;
    endfunction

    function block_t cipher_block(mode_e mode, block_t block);
      word_t left;
      word_t right;
      word_t mixed;
      int    rnd;
      left  = block[BlockWidth-1:WordWidth];
      right = block[WordWidth-1:0];
      for (rnd = 0; rnd < NumRounds; rnd++) begin
        mixed = left ^ round_mix(right, key_bank[round_key(mode, rnd)]);
        left  = right;
        right = mixed;
      end
      // The loop swaps the halves in the last round too, so they are crossed back here.
      return {right, left};
    endfunction

    function void note_input(mode_e mode, block_t block);
      accepted++;
      if (mode == ModeDecrypt) decrypts++;
      expected_blocks.push_back(cipher_block(mode, block));
    endfunction

    function void check_output(block_t actual);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $error("block_out: no result expected, actual %h", actual);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      checked++;
      if (actual !== want) begin
        $error("block_out: expected %h, actual %h", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;
  bit   stall_request;
  int   key_settings;

  cipher_scoreboard sb = new();

  gbc_cfg_if cfg_if ();
  gbc_in_if  in_if ();
  gbc_out_if out_if ();

  gost_block_cipher_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.note_input(mode_e'(in_if.mode), in_if.block_in);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_output(out_if.block_out);
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LongStall - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_block(input mode_e mode, input block_t block);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= mode;
    in_if.block_in <= block;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.expected_blocks.size() != 0) @(negedge clk_i);
  endtask

  task automatic program_keys(input reg_write_t writes [$]);
    foreach (writes[w]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= writes[w].index;
      cfg_if.data  <= writes[w].data;
      do @(posedge clk_i); while (!cfg_if.ready);
      sb.write_key(writes[w].index, writes[w].data);
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    key_settings++;
  endtask

  // Writes all eight key words plus one write to an unused index.
  task automatic load_key(input word_t words [NumKeyWords]);
    reg_write_t writes [$];
    reg_write_t stray;
    int         k;
    for (k = 0; k < NumKeyWords; k++) begin
      writes.push_back('{index: CfgIdxWidth'(k), data: words[k]});
    end
    stray.index = CfgIdxWidth'($urandom_range(FirstUnusedIndex, LastCfgIndex));
    stray.data  = $urandom;
    writes.insert($urandom_range(NumKeyWords), stray);
    program_keys(writes);
  endtask

  function automatic block_t random_block();
    return {$urandom, $urandom};
  endfunction

  initial begin
    word_t      words [NumKeyWords];
    reg_write_t writes [$];
    block_t     plain;
    block_t     edge_value;
    mode_e      mode;
    int         sent;
    int         phase;
    int         pick;
    int         k;

    rst_ni         = 1'b0;
    calm           = 1'b0;
    stall_request  = 1'b0;
    key_settings   = 0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    in_if.valid    = 1'b0;
    in_if.mode     = ModeEncrypt;
    in_if.block_in = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Key bank straight out of reset is all zero.
    send_block(ModeEncrypt, '0);
    send_block(ModeDecrypt, '1);
    wait_idle();

    foreach (words[k]) words[k] = '1;
    load_key(words);
    send_block(ModeEncrypt, '0);
    send_block(ModeEncrypt, '1);
    send_block(ModeDecrypt, '0);
    send_block(ModeDecrypt, '1);
    wait_idle();

    foreach (words[k]) words[k] = $urandom;
    load_key(words);
    send_block(ModeEncrypt, 64'h8000_0000_0000_0001);
    send_block(ModeEncrypt, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(ModeDecrypt, 64'h5555_5555_5555_5555);
    send_block(ModeEncrypt, 64'hFFFF_FFFF_0000_0000);
    send_block(ModeDecrypt, 64'h0000_0000_FFFF_FFFF);
    plain = random_block();
    send_block(ModeEncrypt, plain);
    send_block(ModeDecrypt, sb.cipher_block(ModeEncrypt, plain));
    wait_idle();

    // A lone key word rewrite, and writes to the first and the top unused index,
    // which must leave the bank alone.
    writes = '{'{index: LastCfgIndex, data: '1},
               '{index: CfgIdxWidth'(3), data: 32'h8000_0001},
               '{index: FirstUnusedIndex, data: '0}};
    program_keys(writes);
    send_block(ModeEncrypt, random_block());
    send_block(ModeDecrypt, random_block());
    wait_idle();

    for (phase = 0; phase < RandomPhases; phase++) begin
      for (k = 0; k < NumKeyWords; k++) begin
        words[k] = (phase == 2) ? ((k % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555) : $urandom;
      end
      load_key(words);
      // The first phase opens with a long result hold-off so the core fills
      // up and drops its input ready; the fourth runs with no idling at all.
      if (phase == 0) stall_request = 1'b1;
      calm = (phase == 3);
      sent = 0;
      while (sent < RandomItems / RandomPhases) begin
        pick = $urandom_range(99);
        mode = mode_e'($urandom_range(1));
        if (pick < 20) begin
          plain = random_block();
          send_block(ModeEncrypt, plain);
          send_block(ModeDecrypt, sb.cipher_block(ModeEncrypt, plain));
          sent += 2;
        end else if (pick < 30) begin
          case ($urandom_range(3))
            0: edge_value = '0;
            1: edge_value = '1;
            2: edge_value = block_t'(1) << $urandom_range(BlockWidth - 1);
            default: edge_value = ~(block_t'(1) << $urandom_range(BlockWidth - 1));
          endcase
          send_block(mode, edge_value);
          sent++;
        end else begin
          send_block(mode, random_block());
          sent++;
        end
      end
      wait_idle();
      calm = 1'b0;
    end

    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d blocks (%0d decrypted) under %0d key settings; %0d results checked.",
             sb.accepted, sb.decrypts, key_settings, sb.checked);
    $display("Traffic included a %0d-cycle output hold-off and random idling on both channels.",
             LongStall);
    if (sb.errors == 0 && sb.expected_blocks.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: gost_block_cipher_core.f
design/gbc_pkg.sv
design/gbc_if.sv
design/gbc_key_regs.sv
design/gbc_round_cell.sv
design/gost_block_cipher_core.sv
tb/gost_block_cipher_core_tb.sv
